FILE: hdl/bgs_pkg.sv
// ----------------------------------------------------------------------------
// bgs_pkg
// Types, register codes, reset values and the lamp table shared by the
// barrier gate sequencer.
// ----------------------------------------------------------------------------
package bgs_pkg;

    localparam int PULSE_W = 16;
    localparam int STEP_W  = 10;
    localparam int LAMP_W  = 4;
    localparam int PHASE_W = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [PULSE_W-1:0] PULSE_UP_RST   = 16'd4200;
    localparam logic [PULSE_W-1:0] PULSE_DOWN_RST = 16'd2750;
    localparam logic [STEP_W-1:0]  RAMP_STEP_RST  = 10'd10;
    localparam logic [PULSE_W-1:0] PULSE_MAX      = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PULSE_UP   = 2'd0,
        CFG_PULSE_DOWN = 2'd1,
        CFG_RAMP_STEP  = 2'd2
    } cfg_index_t;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE        = 4'd0,
        PH_ENTRY_OPEN  = 4'd1,
        PH_EXIT_OPEN   = 4'd2,
        PH_ENTRY_RAISE = 4'd3,
        PH_EXIT_RAISE  = 4'd4,
        PH_ENTRY_PASS  = 4'd5,
        PH_EXIT_PASS   = 4'd6,
        PH_ENTRY_CLEAR = 4'd7,
        PH_EXIT_CLEAR  = 4'd8,
        PH_LOWER       = 4'd9
    } phase_t;

    typedef struct packed {
        logic action;
        logic sensor_entry;
        logic sensor_exit;
    } bgs_in_t;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_width;
        logic [LAMP_W-1:0]  lamp_bits;
        logic [PHASE_W-1:0] gate_phase;
    } bgs_out_t;

    typedef struct packed {
        logic [PULSE_W-1:0] pulse_up;
        logic [PULSE_W-1:0] pulse_down;
        logic [STEP_W-1:0]  ramp_step;
    } bgs_cfg_t;

    function automatic logic [LAMP_W-1:0] table_lamps(input phase_t ph);
        logic [LAMP_W-1:0] lamps;
        case (ph)
            PH_IDLE:        lamps = 4'h9;
            PH_ENTRY_OPEN:  lamps = 4'h8;
            PH_EXIT_OPEN:   lamps = 4'h1;
            PH_ENTRY_RAISE: lamps = 4'h8;
            PH_EXIT_RAISE:  lamps = 4'h1;
            PH_ENTRY_PASS:  lamps = 4'h8;
            PH_EXIT_PASS:   lamps = 4'h1;
            PH_ENTRY_CLEAR: lamps = 4'h8;
            PH_EXIT_CLEAR:  lamps = 4'h1;
            PH_LOWER:       lamps = 4'h0;
            default:        lamps = 4'h0;
        endcase
        return lamps;
    endfunction

endpackage

FILE: hdl/bgs_cfg_regs.sv
// ----------------------------------------------------------------------------
// bgs_cfg_regs
// Holds the pulse limits and the ramp step written through the config port.
// ----------------------------------------------------------------------------
module bgs_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bgs_pkg::PULSE_W-1:0]    cfg_data,
    output bgs_pkg::bgs_cfg_t              cfg
);
    import bgs_pkg::*;

    bgs_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_up   <= PULSE_UP_RST;
            cfg_reg.pulse_down <= PULSE_DOWN_RST;
            cfg_reg.ramp_step  <= RAMP_STEP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PULSE_UP:   cfg_reg.pulse_up   <= cfg_data;
                CFG_PULSE_DOWN: cfg_reg.pulse_down <= cfg_data;
                CFG_RAMP_STEP:  cfg_reg.ramp_step  <= cfg_data[STEP_W-1:0];
                default:        ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/bgs_core.sv
// ----------------------------------------------------------------------------
// bgs_core
// Phase, pulse, lamp and blink state with the per-tick update logic.
// ----------------------------------------------------------------------------
module bgs_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  bgs_pkg::bgs_in_t   item,
    input  bgs_pkg::bgs_cfg_t  cfg,
    output bgs_pkg::bgs_out_t  result
);
    import bgs_pkg::*;

    phase_t               phase_reg, phase_next;
    logic [PULSE_W-1:0]   pulse_reg, pulse_next;
    logic [LAMP_W-1:0]    lamps_reg, lamps_next;
    logic                 blink_entry_reg, blink_entry_next;
    logic                 blink_exit_reg, blink_exit_next;

    logic [PULSE_W:0]     ramp_sum;
    logic [PULSE_W-1:0]   ramp_up;
    logic [PULSE_W-1:0]   ramp_down;
    logic [PULSE_W-1:0]   step_ext;
    logic                 far_sensor;
    logic                 raise_done;
    logic                 lower_done;

    assign step_ext   = {{(PULSE_W-STEP_W){1'b0}}, cfg.ramp_step};
    assign ramp_sum   = {1'b0, pulse_reg} + {1'b0, step_ext};
    assign ramp_up    = ramp_sum[PULSE_W] ? PULSE_MAX : ramp_sum[PULSE_W-1:0];
    assign ramp_down  = (pulse_reg > step_ext) ? (pulse_reg - step_ext) : '0;
    assign far_sensor = (phase_reg == PH_ENTRY_RAISE) ? item.sensor_exit
                                                      : item.sensor_entry;
    assign raise_done = (ramp_up >= cfg.pulse_up) || far_sensor;
    assign lower_done = (ramp_down <= cfg.pulse_down);

    always_comb
    begin
        phase_next = phase_reg;
        if (!item.action)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (item.sensor_exit)
                        phase_next = PH_EXIT_OPEN;
                    else if (item.sensor_entry)
                        phase_next = PH_ENTRY_OPEN;
                end
                PH_ENTRY_OPEN:  phase_next = PH_ENTRY_RAISE;
                PH_EXIT_OPEN:   phase_next = PH_EXIT_RAISE;
                PH_ENTRY_RAISE: if (raise_done) phase_next = PH_ENTRY_PASS;
                PH_EXIT_RAISE:  if (raise_done) phase_next = PH_EXIT_PASS;
                PH_ENTRY_PASS:  if (!item.sensor_entry) phase_next = PH_ENTRY_CLEAR;
                PH_EXIT_PASS:   if (!item.sensor_exit) phase_next = PH_EXIT_CLEAR;
                PH_ENTRY_CLEAR: if (!item.sensor_exit) phase_next = PH_LOWER;
                PH_EXIT_CLEAR:  if (!item.sensor_entry) phase_next = PH_LOWER;
                PH_LOWER:       if (lower_done) phase_next = PH_IDLE;
                default:        phase_next = PH_IDLE;
            endcase
        end
    end

    always_comb
    begin
        pulse_next       = pulse_reg;
        lamps_next       = lamps_reg;
        blink_entry_next = blink_entry_reg;
        blink_exit_next  = blink_exit_reg;
        if (item.action)
        begin
            case (phase_reg)
                PH_ENTRY_OPEN, PH_ENTRY_RAISE, PH_ENTRY_PASS, PH_ENTRY_CLEAR:
                begin
                    blink_entry_next = !blink_entry_reg;
                    lamps_next = {lamps_reg[3], !blink_entry_reg, lamps_reg[1:0]};
                end
                PH_EXIT_OPEN, PH_EXIT_RAISE, PH_EXIT_PASS, PH_EXIT_CLEAR:
                begin
                    blink_exit_next = !blink_exit_reg;
                    lamps_next = {!blink_exit_reg, lamps_reg[2:0]};
                end
                default:
                begin
                    lamps_next       = table_lamps(phase_reg);
                    blink_entry_next = 1'b0;
                    blink_exit_next  = 1'b0;
                end
            endcase
        end
        else
        begin
            lamps_next = table_lamps(phase_reg);
            case (phase_reg)
                PH_IDLE:        pulse_next = cfg.pulse_down;
                PH_ENTRY_RAISE,
                PH_EXIT_RAISE:  pulse_next = raise_done ? cfg.pulse_up : ramp_up;
                PH_LOWER:       pulse_next = lower_done ? cfg.pulse_down : ramp_down;
                default:        pulse_next = pulse_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            pulse_reg       <= PULSE_DOWN_RST;
            lamps_reg       <= '0;
            blink_entry_reg <= 1'b0;
            blink_exit_reg  <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            pulse_reg       <= pulse_next;
            lamps_reg       <= lamps_next;
            blink_entry_reg <= blink_entry_next;
            blink_exit_reg  <= blink_exit_next;
        end
    end

    assign result.pulse_width = pulse_next;
    assign result.lamp_bits   = lamps_next;
    assign result.gate_phase  = phase_next;

endmodule

FILE: hdl/barrier_gate_sequencer.sv
// ----------------------------------------------------------------------------
// barrier_gate_sequencer
// Ten-phase barrier gate controller: one tick in, one status transfer out.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------
//   in      | input     | in_valid / in_ready    | action, sensor levels
//   out     | output    | out_valid / out_ready  | pulse, lamps, phase
//   cfg     | input     | cfg_we                 | cfg_index, cfg_data
//
// One tick per cycle sustained while out_ready holds; a tick goes from the
// input register to the result register, with the state update between.
// Reset puts the phase at idle, the pulse at 2750 and the limits at defaults.
// A stalled result holds the result register; the input register then
// holds one more tick before in_ready drops.
// ----------------------------------------------------------------------------
module barrier_gate_sequencer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  bgs_pkg::bgs_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output bgs_pkg::bgs_out_t              out_data,
    input  logic                           cfg_we,
    input  logic [bgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bgs_pkg::PULSE_W-1:0]    cfg_data
);
    import bgs_pkg::*;

    bgs_cfg_t  cfg;
    bgs_in_t   in_data_reg;
    logic      in_valid_reg;
    bgs_out_t  out_data_reg;
    logic      out_valid_reg;
    bgs_out_t  result;
    logic      advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    bgs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bgs_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_data_reg <= in_data;
        if (advance)
            out_data_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: hdl/bgs_checker.sv
// ----------------------------------------------------------------------------
// bgs_checker
// Port-level checks for the barrier gate sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module bgs_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  bgs_pkg::bgs_in_t               in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  bgs_pkg::bgs_out_t              out_data,
    input  logic                           cfg_we,
    input  logic [bgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bgs_pkg::PULSE_W-1:0]    cfg_data
);
    import bgs_pkg::*;

    logic unused_ok;
    assign unused_ok = &{in_valid, in_data, cfg_we, cfg_index, cfg_data};

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed or dropped while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with no result pending");

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.gate_phase <= 4'd9)
        else $error("phase out of range");

    a_lamp_bit1: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !out_data.lamp_bits[1])
        else $error("lamp bit 1 lit");

endmodule

bind barrier_gate_sequencer bgs_checker u_bgs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);
